// ----- rtl/brf_pkg.sv -----
`timescale 1ns / 1ps

package brf_pkg;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type     opcode;
      logic [7:0] data_in;
      logic [7:0] peek_offset;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       accepted;
      logic [7:0] fill_count;
      logic [7:0] space_left;
      logic       is_empty;
      logic       is_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic fetch;
   } cmd_type;

   typedef struct packed {
      logic read_issue;
   } stat_type;

endpackage

// ----- rtl/brf_ram.sv -----
`timescale 1ns / 1ps

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/brf_ctrl.sv -----
`timescale 1ns / 1ps

module brf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  brf_pkg::stat_type stat,
   output brf_pkg::cmd_type  cmd
);

   import brf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.read_issue ? ST_FETCH : ST_RESP;
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("transaction accepted while a result is pending");

   a_accept_execs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec)
      else $error("accepted transaction not executed");

   a_fetch_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> $past(cmd.exec && stat.read_issue))
      else $error("fetch without a preceding read");

   a_result_after_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> rsp_valid)
      else $error("fetched data not presented");
`endif

endmodule

// ----- rtl/brf_dp.sv -----
`timescale 1ns / 1ps

module brf_dp #(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  brf_pkg::req_type  req_data,
   output brf_pkg::rsp_type  rsp_data,
   input  brf_pkg::cmd_type  cmd,
   output brf_pkg::stat_type stat
);

   import brf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int XW = (AW > 8) ? AW : 8;

   req_type       req_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic [AW-1:0] wp_ff;
   logic [AW-1:0] wp_in;
   logic [AW-1:0] rp_ff;
   logic [AW-1:0] rp_in;

   logic [AW-1:0] fill_now;
   logic [AW-1:0] fill_after;
   logic [AW-1:0] space_after;
   logic [XW-1:0] fill_after_x;
   logic [XW-1:0] space_after_x;
   logic [XW-1:0] peek_sum;
   logic          push_ok;
   logic          pop_ok;
   logic          peek_ok;
   logic          clear_op;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   assign fill_now = wp_ff - rp_ff;
   assign peek_sum = XW'(rp_ff) + XW'(req_ff.peek_offset);

   assign push_ok  = (req_ff.opcode == OP_PUSH) && (fill_now != {AW{1'b1}});
   assign pop_ok   = (req_ff.opcode == OP_POP) && (fill_now != '0);
   assign peek_ok  = (req_ff.opcode == OP_PEEK) &&
                     (XW'(req_ff.peek_offset) < XW'(fill_now));
   assign clear_op = (req_ff.opcode == OP_CLEAR);

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (cmd.exec) begin
         if (push_ok) wp_in = wp_ff + AW'(1);
         if (pop_ok) begin
            rp_in = rp_ff + AW'(1);
         end else if (clear_op) begin
            rp_in = wp_ff;
         end
      end
   end

   assign fill_after    = wp_in - rp_in;
   assign space_after   = ~fill_after;
   assign fill_after_x  = XW'(fill_after);
   assign space_after_x = XW'(space_after);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in.data_out   = '0;
         rsp_in.accepted   = push_ok | pop_ok | peek_ok | clear_op;
         rsp_in.fill_count = fill_after_x[7:0];
         rsp_in.space_left = space_after_x[7:0];
         rsp_in.is_empty   = (wp_in == rp_in);
         rsp_in.is_full    = ((wp_in + AW'(1)) == rp_in);
      end else if (cmd.fetch) begin
         rsp_in.data_out = ram_rd_data;
      end
   end

   assign ram_wr_en   = cmd.exec & push_ok;
   assign ram_rd_en   = cmd.exec & (pop_ok | peek_ok);
   assign ram_rd_addr = pop_ok ? rp_ff : peek_sum[AW-1:0];

   brf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_ff.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign stat.read_issue = pop_ok | peek_ok;
   assign rsp_data        = rsp_ff;

`ifndef NO_ASSERTIONS
   a_not_empty_and_full: assert property (@(posedge clock) disable iff (reset)
      !((wp_ff == rp_ff) && ((wp_ff + AW'(1)) == rp_ff)))
      else $error("ring reports empty and full together");

   a_push_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && push_ok) |=> (wp_ff == $past(wp_ff) + AW'(1)))
      else $error("push did not advance head");

   a_pointers_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> ($stable(wp_ff) && $stable(rp_ff)))
      else $error("pointer moved outside execute");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("write and read issued for one transaction");
`endif

endmodule

// ----- rtl/byte_ring_fifo_unit.sv -----
`timescale 1ns / 1ps

// Byte FIFO in a ring of DEPTH slots (power of two, 2 to 65536) holding up to
// DEPTH-1 bytes. Each request carries push, pop, peek at an offset from the
// oldest byte, or clear, and yields one response with the byte popped or
// peeked, an accepted flag, and the fill, free space, empty and full status
// after the operation (counts modulo 256). One transaction is handled at a
// time: push, clear and refused operations pass from the execute state to
// the response state, pop and peek from execute through fetch to response
// because of the registered read of the byte store; a new request is taken
// the cycle after the response leaves.
module byte_ring_fifo_unit #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data
);

   import brf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   brf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// ----- sim/byte_ring_fifo_checker.sv -----
`timescale 1ns / 1ps

module byte_ring_fifo_checker #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  brf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  brf_pkg::rsp_type rsp_data,
   output int               failures,
   output int               pending
);

   import brf_pkg::*;

   localparam int MASK = DEPTH - 1;

   logic [7:0] ring_bytes [DEPTH];
   int         head;
   int         tail;
   int         rsp_count;
   rsp_type    expected_rsp [$];

   function automatic rsp_type ring_apply(req_type r);
      rsp_type res;
      int      used;
      int      room;
      res = '0;
      used = (head - tail) & MASK;
      case (r.opcode)
         OP_PUSH: begin
            if (used != DEPTH - 1) begin
               ring_bytes[head] = r.data_in;
               head = (head + 1) & MASK;
               res.accepted = 1'b1;
            end
         end
         OP_POP: begin
            if (used != 0) begin
               res.data_out = ring_bytes[tail];
               tail = (tail + 1) & MASK;
               res.accepted = 1'b1;
            end
         end
         OP_PEEK: begin
            if (int'(r.peek_offset) < used) begin
               res.data_out = ring_bytes[(tail + int'(r.peek_offset)) & MASK];
               res.accepted = 1'b1;
            end
         end
         default: begin
            tail = head;
            res.accepted = 1'b1;
         end
      endcase
      used = (head - tail) & MASK;
      room = DEPTH - 1 - used;
      res.fill_count = 8'(used);
      res.space_left = 8'(room);
      res.is_empty = (head == tail);
      res.is_full = (((head + 1) & MASK) == tail);
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         if (failures < 10)
            $display("%0t: transaction %0d %s mismatch: expected %0d, got %0d",
                     $realtime, rsp_count, name, want, got);
         failures++;
      end
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      head = 0;
      tail = 0;
      rsp_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head = 0;
         tail = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected transaction on response channel", $realtime);
               failures++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("data_out", want.data_out, rsp_data.data_out);
               check_field("accepted", want.accepted, rsp_data.accepted);
               check_field("fill_count", want.fill_count, rsp_data.fill_count);
               check_field("space_left", want.space_left, rsp_data.space_left);
               check_field("is_empty", want.is_empty, rsp_data.is_empty);
               check_field("is_full", want.is_full, rsp_data.is_full);
            end
            rsp_count++;
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(ring_apply(req_data));
      end
      pending = expected_rsp.size();
   end

endmodule

// ----- sim/byte_ring_fifo_unit_tb.sv -----
`timescale 1ns / 1ps

module byte_ring_fifo_unit_tb;

   import brf_pkg::*;

   localparam int DEPTH     = 256;
   localparam int CAPACITY  = DEPTH - 1;
   localparam int ITEM_GOAL = 1550;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      failures;
   int      pending;

   int      occupancy;
   int      sent;
   bit      burst;

   byte_ring_fifo_unit #(.DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   byte_ring_fifo_checker #(.DEPTH(DEPTH)) ring_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (burst || k < 60)
         return 0;
      else if (k < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(input op_type op, input logic [7:0] din, input logic [7:0] offset);
      int      gap;
      req_type r;
      gap = pick_gap();
      r.opcode = op;
      r.data_in = din;
      r.peek_offset = offset;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      case (op)
         OP_PUSH:  if (occupancy < CAPACITY) occupancy++;
         OP_POP:   if (occupancy > 0) occupancy--;
         OP_CLEAR: occupancy = 0;
         default:  ;
      endcase
      sent++;
   endtask

   function automatic logic [7:0] near_offset();
      int hi;
      hi = (occupancy > 254) ? 254 : occupancy;
      if ($urandom_range(0, 1))
         return 8'($urandom_range((hi > 2) ? hi - 2 : 0, hi));
      return 8'($urandom_range(0, 254));
   endfunction

   task automatic send_peek();
      send(OP_PEEK, 8'($urandom), near_offset());
   endtask

   task automatic drain_to_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         int k;
         int n;
         logic v;
         k = $urandom_range(0, 99);
         if (k < 45) begin
            v = 1'b0;
            n = $urandom_range(1, 6);
         end else if (k < 55) begin
            v = 1'b0;
            n = $urandom_range(40, 150);
         end else if (k < 92) begin
            v = 1'b1;
            n = $urandom_range(1, 3);
         end else begin
            v = 1'b1;
            n = $urandom_range(10, 40);
         end
         rsp_stall <= v;
         repeat (n) @(negedge clock);
      end
   end

   initial begin
      int phase;
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      occupancy = 0;
      sent = 0;
      burst = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(OP_POP, 8'($urandom), 8'($urandom_range(0, 254)));
      send(OP_PEEK, 8'($urandom), 8'd0);
      send(OP_CLEAR, 8'($urandom), 8'($urandom_range(0, 254)));
      send(OP_PUSH, 8'h00, 8'd0);
      send(OP_PUSH, 8'hFF, 8'd254);
      send(OP_PUSH, 8'hA5, 8'h55);
      send(OP_PEEK, 8'hFF, 8'd0);
      send(OP_PEEK, 8'h00, 8'd1);
      send(OP_PEEK, 8'h00, 8'd2);
      send(OP_PEEK, 8'h00, 8'd3);
      send(OP_PEEK, 8'h00, 8'd254);
      send(OP_POP, 8'h00, 8'd0);
      send(OP_POP, 8'hFF, 8'hFE);
      send(OP_PUSH, 8'h5A, 8'h00);
      send(OP_PEEK, 8'h00, 8'h80);
      send(OP_POP, 8'h00, 8'd0);
      send(OP_POP, 8'h00, 8'd0);
      send(OP_POP, 8'h00, 8'd0);
      send(OP_PUSH, 8'h3C, 8'd0);
      send(OP_PUSH, 8'hC3, 8'd0);
      send(OP_CLEAR, 8'hFF, 8'hFE);
      send(OP_PEEK, 8'h00, 8'd0);
      send(OP_POP, 8'h00, 8'd0);
      drain_to_idle();

      phase = 0;
      while (sent < ITEM_GOAL) begin
         k = (phase == 0) ? 0 : (phase == 1) ? 25 : $urandom_range(0, 99);
         burst = ($urandom_range(0, 4) == 0);
         if (k < 20) begin
            // fill to capacity, then hammer the full ring
            if ($urandom_range(0, 1))
               send(OP_CLEAR, 8'($urandom), 8'($urandom_range(0, 254)));
            while (occupancy < CAPACITY) begin
               if ($urandom_range(0, 99) < 90)
                  send(OP_PUSH, 8'($urandom), 8'($urandom_range(0, 254)));
               else
                  send_peek();
            end
            repeat ($urandom_range(2, 5)) begin
               send(OP_PUSH, 8'($urandom), 8'($urandom_range(0, 254)));
               send_peek();
            end
            send(OP_PEEK, 8'($urandom), 8'd254);
         end else if (k < 40) begin
            // empty it out, then keep popping
            while (occupancy > 0) begin
               if ($urandom_range(0, 99) < 85)
                  send(OP_POP, 8'($urandom), 8'($urandom_range(0, 254)));
               else
                  send_peek();
            end
            repeat ($urandom_range(2, 4))
               send(OP_POP, 8'($urandom), 8'($urandom_range(0, 254)));
            send(OP_PEEK, 8'($urandom), 8'd0);
         end else begin
            repeat ($urandom_range(40, 120)) begin
               k = $urandom_range(0, 99);
               if (k < 40)
                  send(OP_PUSH, 8'($urandom), 8'($urandom_range(0, 254)));
               else if (k < 75)
                  send(OP_POP, 8'($urandom), 8'($urandom_range(0, 254)));
               else if (k < 96)
                  send_peek();
               else
                  send(OP_CLEAR, 8'($urandom), 8'($urandom_range(0, 254)));
            end
         end
         if ($urandom_range(0, 3) == 0)
            drain_to_idle();
         phase++;
      end

      drain_to_idle();
      repeat (20) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
